// File: rtl/hrld_pkg.sv
// Shared types and constants for the hex record line decoder.
// No dependencies; imported by hrld_step and hex_record_line_decoder_top.
`timescale 1ns / 1ps

package hrld_pkg;

    localparam logic [9:0] POS_MAX = 10'd1023;

    // Record type codes
    localparam logic [7:0] REC_DATA = 8'd0;
    localparam logic [7:0] REC_EOF  = 8'd1;
    localparam logic [7:0] REC_ESA  = 8'd2;
    localparam logic [7:0] REC_SSA  = 8'd3;
    localparam logic [7:0] REC_ELA  = 8'd4;
    localparam logic [7:0] REC_SLA  = 8'd5;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_DIG  = 3'd2,
        ST_BAD_TYPE = 3'd3,
        ST_BAD_LEN  = 3'd4,
        ST_BAD_SUM  = 3'd5
    } status_t;

    typedef struct packed {
        logic [9:0]  char_position;
        logic [3:0]  high_nibble;
        logic [7:0]  count_held;
        logic [15:0] address_held;
        logic [7:0]  type_held;
        logic [7:0]  running_sum;
        logic [31:0] payload_shift;
        logic        digit_error;
    } line_state_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  byte_offset;
        logic [15:0] load_address;
        logic [7:0]  data_byte;
        logic [7:0]  record_kind;
        logic [7:0]  byte_count;
        logic [31:0] payload_value;
        status_t     status;
        logic        last;
    } result_t;

endpackage

// File: rtl/hrld_step.sv
// Per-character decode step: digit decode, byte assembly, field capture and
// end-of-line checks. Purely combinational; depends on hrld_pkg.
`timescale 1ns / 1ps

module hrld_step (
    input  logic                  ascii_char_valid,
    input  logic [7:0]            ascii_char,
    input  logic                  end_of_line,
    input  hrld_pkg::line_state_t state_cur,
    output hrld_pkg::line_state_t state_next,
    output logic                  data_hit,
    output hrld_pkg::result_t     data_res,
    output hrld_pkg::result_t     stat_res
);
    import hrld_pkg::*;

    logic        nib_ok;
    logic [3:0]  nib;
    logic [10:0] rec_limit;
    logic        in_rec;
    logic [8:0]  byte_idx;
    logic [8:0]  data_lim;
    logic [7:0]  byte_val;
    logic [7:0]  offset;
    logic [10:0] need_len;
    logic        short_line;
    logic        fit;
    line_state_t s;

    // hex digit decode, non-hex reads as zero
    always_comb begin
        nib_ok = 1'b1;
        nib    = 4'd0;
        if (ascii_char >= 8'h30 && ascii_char <= 8'h39) begin
            nib = 4'(ascii_char - 8'h30);
        end else if (ascii_char >= 8'h41 && ascii_char <= 8'h46) begin
            nib = 4'(ascii_char - 8'h37);
        end else if (ascii_char >= 8'h61 && ascii_char <= 8'h66) begin
            nib = 4'(ascii_char - 8'h57);
        end else begin
            nib_ok = 1'b0;
        end
    end

    always_comb begin
        rec_limit = 11'd10 + {2'b00, state_cur.count_held, 1'b0};
        in_rec    = (state_cur.char_position != 10'd0) &&
                    ((state_cur.char_position <= 10'd2) ||
                     ({1'b0, state_cur.char_position} <= rec_limit));
        byte_idx  = state_cur.char_position[9:1] - 9'd1;
        data_lim  = 9'd4 + {1'b0, state_cur.count_held};
        byte_val  = {state_cur.high_nibble, nib};
        offset    = 8'(byte_idx - 9'd4);

        s        = state_cur;
        data_hit = 1'b0;
        data_res = '0;

        if (in_rec) begin
            if (!nib_ok) begin
                s.digit_error = 1'b1;
            end
            if (state_cur.char_position[0]) begin
                s.high_nibble = nib;
            end else begin
                s.running_sum = state_cur.running_sum + byte_val;
                if (byte_idx == 9'd0) begin
                    s.count_held = byte_val;
                end else if (byte_idx == 9'd1) begin
                    s.address_held = {byte_val, state_cur.address_held[7:0]};
                end else if (byte_idx == 9'd2) begin
                    s.address_held = {state_cur.address_held[15:8], byte_val};
                end else if (byte_idx == 9'd3) begin
                    s.type_held = byte_val;
                end else if (byte_idx < data_lim) begin
                    data_hit      = ascii_char_valid;
                    s.payload_shift = {state_cur.payload_shift[23:0], byte_val};
                end
            end
        end

        if (state_cur.char_position != POS_MAX) begin
            s.char_position = state_cur.char_position + 10'd1;
        end

        data_res.kind          = 1'b0;
        data_res.byte_offset   = offset;
        data_res.load_address  = state_cur.address_held + {8'd0, offset};
        data_res.data_byte     = byte_val;
        data_res.record_kind   = s.type_held;
        data_res.byte_count    = s.count_held;
        data_res.payload_value = '0;
        data_res.status        = ST_OK;
        data_res.last          = 1'b0;

        // end-of-line checks, first failing one wins
        need_len   = 11'd11 + {2'b00, s.count_held, 1'b0};
        short_line = (s.char_position < 10'd3) || ({1'b0, s.char_position} < need_len);
        case (s.type_held)
            REC_DATA: fit = (s.count_held != 8'd0);
            REC_EOF:  fit = (s.count_held == 8'd0);
            REC_ESA,
            REC_ELA:  fit = (s.count_held == 8'd2);
            default:  fit = (s.count_held == 8'd4) && (s.address_held == 16'd0);
        endcase

        stat_res.kind          = 1'b1;
        stat_res.byte_offset   = 8'd0;
        stat_res.load_address  = s.address_held;
        stat_res.data_byte     = 8'd0;
        stat_res.record_kind   = s.type_held;
        stat_res.byte_count    = s.count_held;
        stat_res.payload_value = (s.type_held >= REC_ESA && s.type_held <= REC_SLA) ?
                                 s.payload_shift : 32'd0;
        stat_res.last          = 1'b1;
        if (short_line) begin
            stat_res.status = ST_SHORT;
        end else if (s.digit_error) begin
            stat_res.status = ST_BAD_DIG;
        end else if (s.type_held > REC_SLA) begin
            stat_res.status = ST_BAD_TYPE;
        end else if (!fit) begin
            stat_res.status = ST_BAD_LEN;
        end else if (s.running_sum != 8'd0) begin
            stat_res.status = ST_BAD_SUM;
        end else begin
            stat_res.status = ST_OK;
        end

        // line closes: drop all line state
        state_next = end_of_line ? line_state_t'('0) : s;
    end

endmodule

// File: rtl/hex_record_line_decoder_top.sv
// Throughput: one character per cycle while s_ready is high; a data byte on
// the last character of a line gives two results, drained one per cycle
// while m_ready is high through a 4-entry result queue.
// s_ready is low while fewer than two queue entries are free.
// Reset (aresetn low, synchronous) clears the line state and empties the queue.
// Depends on hrld_pkg and hrld_step.
`timescale 1ns / 1ps

module hex_record_line_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ascii_char,
    input  logic        s_end_of_line,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_byte_offset,
    output logic [15:0] m_load_address,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_record_kind,
    output logic [7:0]  m_byte_count,
    output logic [31:0] m_payload_value,
    output logic [2:0]  m_status,
    output logic        m_last
);
    import hrld_pkg::*;

    line_state_t state_reg, state_next;
    result_t     q_reg [Q_DEPTH];
    logic [Q_AW-1:0] head_reg, head_next;
    logic [Q_AW-1:0] tail_reg, tail_next;
    logic [Q_CW-1:0] count_reg, count_next;

    logic    s_accept;
    logic    m_accept;
    logic    data_hit;
    result_t data_res;
    result_t stat_res;
    result_t head_item;
    logic [Q_CW-1:0] push_n;
    logic [Q_AW-1:0] stat_slot;

    assign s_ready  = (count_reg <= Q_CW'(Q_DEPTH - 2));
    assign s_accept = s_valid && s_ready;
    assign m_valid  = (count_reg != '0);
    assign m_accept = m_valid && m_ready;

    hrld_step u_step (
        .ascii_char_valid (s_accept),
        .ascii_char       (s_ascii_char),
        .end_of_line      (s_end_of_line),
        .state_cur        (state_reg),
        .state_next       (state_next),
        .data_hit         (data_hit),
        .data_res         (data_res),
        .stat_res         (stat_res)
    );

    always_comb begin
        push_n     = s_accept ? (Q_CW'(data_hit) + Q_CW'(s_end_of_line)) : '0;
        stat_slot  = data_hit ? tail_reg + 1'b1 : tail_reg;
        tail_next  = tail_reg + Q_AW'(push_n);
        head_next  = m_accept ? head_reg + 1'b1 : head_reg;
        count_next = count_reg + push_n - Q_CW'(m_accept);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // data byte goes first, status behind it
    always_ff @(posedge aclk) begin
        if (s_accept && data_hit) begin
            q_reg[tail_reg] <= data_res;
        end
        if (s_accept && s_end_of_line) begin
            q_reg[stat_slot] <= stat_res;
        end
    end

    assign head_item       = q_reg[head_reg];
    assign m_kind          = head_item.kind;
    assign m_byte_offset   = head_item.byte_offset;
    assign m_load_address  = head_item.load_address;
    assign m_data_byte     = head_item.data_byte;
    assign m_record_kind   = head_item.record_kind;
    assign m_byte_count    = head_item.byte_count;
    assign m_payload_value = head_item.payload_value;
    assign m_status        = head_item.status;
    assign m_last          = head_item.last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("result queue overflow");

    a_line_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_end_of_line |=> state_reg.char_position == 10'd0)
        else $error("line state not cleared after end of line");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == m_last))
        else $error("last flag does not match result kind");

    a_fill_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_reg - head_reg) == Q_AW'(count_reg))
        else $error("queue pointers out of step with count");
`endif

endmodule
